// ===== design/bfs_pkg.sv =====
`default_nettype none
package bfs_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned CntWidth   = 4;

  localparam logic [6:0] GroupMask = 7'h7F;
  localparam logic [7:0] ContBit   = 8'h80;
  localparam int unsigned GroupBits = 7;

  // Index of the tenth byte: a 64-bit varint ends there at the latest.
  localparam logic [CntWidth-1:0] VarLastIdx = 4'd9;

  localparam logic ActFixed  = 1'b0;
  localparam logic ActVarint = 1'b1;

  localparam logic [1:0] Wc16 = 2'd0;
  localparam logic [1:0] Wc32 = 2'd1;
  localparam logic [1:0] Wc64 = 2'd2;
  localparam logic [1:0] Wc8B = 2'd3;

  // Descriptor handed from the classifier to the byte emitter.
  typedef struct packed {
    logic                  varint;
    logic [ValueWidth-1:0] data;
    logic [CntWidth-1:0]   cnt;
  } desc_t;

  // Index of the last byte of a fixed-width write.
  function automatic logic [CntWidth-1:0] fixed_last_idx(input logic [1:0] wc);
    logic [CntWidth-1:0] r;
    begin
      case (wc)
        Wc16:    r = 4'd1;
        Wc32:    r = 4'd2;
        Wc64:    r = 4'd3;
        default: r = 4'd7;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// ===== design/bfs_front.sv =====
`default_nettype none
module bfs_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic                          cfg_big_endian_i,
  input  wire logic                          action_i,
  input  wire logic [1:0]                    width_code_i,
  input  wire logic                          signed_en_i,
  input  wire logic [bfs_pkg::ValueWidth-1:0] value_i,
  output bfs_pkg::desc_t                     desc_o
);
  import bfs_pkg::*;

  logic                  big_endian_q, big_endian_d;
  logic [ValueWidth-1:0] mask;
  logic [ValueWidth-1:0] masked;
  logic [ValueWidth-1:0] shifted;
  logic [ValueWidth-1:0] negated;
  logic [ValueWidth-1:0] var_val;
  logic [ValueWidth-1:0] swapped;
  logic                  neg;

  always_comb begin
    big_endian_d = big_endian_q;
    if (cfg_valid_i) begin
      big_endian_d = cfg_big_endian_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_endian_q <= 1'b0;
    end else begin
      big_endian_q <= big_endian_d;
    end
  end

  // Zigzag-like signed mapping for varints: n >= 0 maps to 2n, n < 0 to -2n+1 within the width's mask.
  always_comb begin
    case (width_code_i)
      Wc16: begin
        mask = {48'd0, 16'hFFFF};
        neg  = value_i[15];
      end
      Wc32: begin
        mask = {32'd0, 32'hFFFF_FFFF};
        neg  = value_i[31];
      end
      default: begin
        mask = {ValueWidth{1'b1}};
        neg  = value_i[63];
      end
    endcase
    masked  = value_i & mask;
    shifted = {masked[ValueWidth-2:0], 1'b0} & mask;
    negated = ((~shifted + 64'd1) & mask) | 64'd1;
    if (signed_en_i && neg) begin
      var_val = negated;
    end else if (signed_en_i) begin
      var_val = shifted;
    end else begin
      var_val = masked;
    end
  end

  // The emitter always takes the low byte first, so big-endian writes are swapped here.
  always_comb begin
    case (width_code_i)
      Wc16:    swapped = {48'd0, value_i[7:0], value_i[15:8]};
      Wc32:    swapped = {40'd0, value_i[7:0], value_i[15:8], value_i[23:16]};
      Wc64:    swapped = {32'd0, value_i[7:0], value_i[15:8], value_i[23:16],
                          value_i[31:24]};
      default: swapped = {value_i[7:0], value_i[15:8], value_i[23:16], value_i[31:24],
                          value_i[39:32], value_i[47:40], value_i[55:48],
                          value_i[63:56]};
    endcase
  end

  always_comb begin
    if (action_i == ActVarint) begin
      desc_o.varint = 1'b1;
      desc_o.data   = var_val;
      desc_o.cnt    = '0;
    end else begin
      desc_o.varint = 1'b0;
      desc_o.data   = big_endian_q ? swapped : value_i;
      desc_o.cnt    = fixed_last_idx(width_code_i);
    end
  end

endmodule
`default_nettype wire

// ===== design/bfs_queue.sv =====
`default_nettype none
module bfs_queue (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire bfs_pkg::desc_t push_data_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          valid_o,
  output bfs_pkg::desc_t pop_data_o
);
  import bfs_pkg::*;

  desc_t      mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = mem_q[rptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wptr_d  = do_push ? ~wptr_q : wptr_q;
    rptr_d  = do_pop ? ~rptr_q : rptr_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/bfs_back.sv =====
`default_nettype none
module bfs_back (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_valid_i,
  input  wire bfs_pkg::desc_t q_data_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            last_o
);
  import bfs_pkg::*;

  logic                  busy_q, busy_d;
  logic                  varint_q;
  logic [ValueWidth-1:0] data_q;
  logic [CntWidth-1:0]   cnt_q;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            byte_q;
  logic                  last_q;
  logic                  advance;
  logic                  cur_last;
  logic [7:0]            cur_byte;
  logic [ValueWidth-1:0] rest;

  assign advance = busy_q && (!out_valid_q || out_ready_i);
  assign rest    = varint_q ? (data_q >> GroupBits) : (data_q >> 8);

  always_comb begin
    if (varint_q) begin
      cur_last = (rest == '0) || (cnt_q == VarLastIdx);
      cur_byte = cur_last ? {1'b0, data_q[6:0] & GroupMask}
                          : (ContBit | {1'b0, data_q[6:0] & GroupMask});
    end else begin
      cur_last = (cnt_q == '0);
      cur_byte = data_q[7:0];
    end
  end

  // A new request is taken as soon as the current one hands over its last byte.
  assign q_pop_o = q_valid_i && (!busy_q || (advance && cur_last));

  always_comb begin
    busy_d = busy_q;
    if (q_pop_o) begin
      busy_d = 1'b1;
    end else if (advance && cur_last) begin
      busy_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      varint_q <= q_data_i.varint;
      data_q   <= q_data_i.data;
      cnt_q    <= q_data_i.cnt;
    end else if (advance) begin
      data_q <= rest;
      cnt_q  <= varint_q ? (cnt_q + 4'd1) : (cnt_q - 4'd1);
    end
    if (advance) begin
      byte_q <= cur_byte;
      last_q <= cur_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = byte_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

// ===== design/binary_field_serializer_top.sv =====
`default_nettype none
// Channel   Direction  Handshake                  Payload
// cfg       in         cfg_valid_i / cfg_ready_o  cfg_big_endian_i
// in        in         in_valid_i / in_ready_o    action_i, width_code_i, signed_en_i, value_i
// out       out        out_valid_o / out_ready_i  out_byte_o, last_o
//
// One byte leaves per cycle unless out_ready_i stalls the output; a request has
// 2, 3, 4 or 8 bytes for fixed writes and 1 to 10 for varints; the byte emitter sets this pace.
// An accepted request is held in the queue, then in the emitter, then in the output byte register.
// A two-entry queue sits between the classifier and the emitter, so new requests are
// taken while the emitter is still busy or the output is stalled.
// Reset empties the queue and the output register and clears big_endian.
module binary_field_serializer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_big_endian_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        action_i,
  input  wire logic [1:0]  width_code_i,
  input  wire logic        signed_en_i,
  input  wire logic [63:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             last_o
);
  import bfs_pkg::*;

  desc_t front_desc;
  desc_t q_desc;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full;

  bfs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_big_endian_i (cfg_big_endian_i),
    .action_i         (action_i),
    .width_code_i     (width_code_i),
    .signed_en_i      (signed_en_i),
    .value_i          (value_i),
    .desc_o           (front_desc)
  );

  bfs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_desc),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_desc)
  );

  bfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_desc),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule
`default_nettype wire
